// ----- rtl/core/bpfa_pkg.sv -----
package bpfa_pkg;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_RESERVE = 2'd3
    } t_cmd;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam int WORD_BITS = 64;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] address;
        logic [31:0] length;
    } t_req;

    typedef struct packed {
        logic [31:0] frame_addr;
        logic [1:0]  status;
    } t_rsp;

endpackage

// ----- rtl/core/bitmap_page_frame_allocator_top.sv -----
// Channel  | Signals                    | Handshake
// command  | i_start, i_cmd (t_req)     | accepted when i_start && !o_busy
// result   | o_done, o_rsp (t_rsp)      | one-cycle strobe, no back-pressure
// The result strobe follows acceptance through the front register, the bitmap walk and S_FIN.
// Free and range commands pass S_RD, S_CHK and S_WR for each 64-block bitmap word touched.
// Allocate scans 64-block words from the lowest, passing S_RD and S_CHK for each word read.
// After reset an init pass (S_INIT) writes ones to every bitmap word, marking all blocks used.
// o_busy stays high from acceptance until the result strobe.
module bitmap_page_frame_allocator_top #(
    parameter int NUM_BLOCKS  = 4096,
    parameter int BLOCK_BYTES = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  bpfa_pkg::t_req i_cmd,
    output logic           o_busy,
    output logic           o_done,
    output bpfa_pkg::t_rsp o_rsp
);

    localparam int BW = $clog2(NUM_BLOCKS + 1) + 1;

    logic          f_valid;
    logic [1:0]    f_cmd;
    logic [BW-1:0] f_first;
    logic [BW-1:0] f_stop;
    logic [1:0]    f_status;
    logic          b_busy;
    logic          r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (i_start && !o_busy) begin
            r_pend <= 1'b1;
        end else if (f_valid) begin
            r_pend <= 1'b0;
        end
    end

    assign o_busy = b_busy || r_pend || f_valid;

    bpfa_front #(.NUM_BLOCKS(NUM_BLOCKS), .BLOCK_BYTES(BLOCK_BYTES), .BW(BW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_start && !o_busy), .i_req(i_cmd),
        .o_valid(f_valid), .o_cmd(f_cmd), .o_first(f_first),
        .o_stop(f_stop), .o_status(f_status)
    );

    bpfa_back #(.NUM_BLOCKS(NUM_BLOCKS), .BLOCK_BYTES(BLOCK_BYTES), .BW(BW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .i_cmd(f_cmd), .i_first(f_first),
        .i_stop(f_stop), .i_status(f_status),
        .o_busy(b_busy), .o_done(o_done), .o_rsp(o_rsp)
    );

endmodule

// ----- rtl/core/bpfa_front.sv -----
module bpfa_front #(
    parameter int NUM_BLOCKS  = 4096,
    parameter int BLOCK_BYTES = 4096,
    parameter int BW          = $clog2(NUM_BLOCKS + 1) + 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  bpfa_pkg::t_req i_req,
    output logic           o_valid,
    output logic [1:0]     o_cmd,
    output logic [BW-1:0]  o_first,
    output logic [BW-1:0]  o_stop,
    output logic [1:0]     o_status
);

    localparam int SH = $clog2(BLOCK_BYTES);

    logic [32:0] first_w;
    logic [33:0] end_w;
    logic [33:0] nb;
    logic [33:0] stop_w;

    assign first_w = {1'b0, i_req.address >> SH};
    assign end_w   = {1'b0, first_w} + {2'b0, i_req.length >> SH};
    assign nb      = 34'(NUM_BLOCKS);
    assign stop_w  = (end_w > nb) ? nb : end_w;

    logic           r_valid;
    logic [1:0]     r_cmd;
    logic [BW-1:0]  r_first;
    logic [BW-1:0]  r_stop;
    logic [1:0]     r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        if (i_valid) begin
            r_cmd <= i_req.command;
            case (bpfa_pkg::t_cmd'(i_req.command))
                bpfa_pkg::CMD_ALLOC: begin
                    r_first  <= '0;
                    r_stop   <= '0;
                    r_status <= bpfa_pkg::ST_OK;
                end
                bpfa_pkg::CMD_FREE: begin
                    if ({1'b0, first_w} < nb) begin
                        r_first  <= BW'(first_w);
                        r_stop   <= BW'(first_w) + BW'(1);
                        r_status <= bpfa_pkg::ST_OK;
                    end else begin
                        r_first  <= '0;
                        r_stop   <= '0;
                        r_status <= bpfa_pkg::ST_RANGE;
                    end
                end
                default: begin
                    if ({1'b0, first_w} < stop_w) begin
                        r_first <= BW'(first_w);
                        r_stop  <= BW'(stop_w);
                    end else begin
                        r_first <= '0;
                        r_stop  <= '0;
                    end
                    r_status <= (end_w > {1'b0, first_w} && end_w > nb) ?
                                bpfa_pkg::ST_RANGE : bpfa_pkg::ST_OK;
                end
            endcase
        end
    end

    assign o_valid  = r_valid;
    assign o_cmd    = r_cmd;
    assign o_first  = r_first;
    assign o_stop   = r_stop;
    assign o_status = r_status;

endmodule

// ----- rtl/core/bpfa_back.sv -----
module bpfa_back #(
    parameter int NUM_BLOCKS  = 4096,
    parameter int BLOCK_BYTES = 4096,
    parameter int BW          = $clog2(NUM_BLOCKS + 1) + 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [1:0]     i_cmd,
    input  logic [BW-1:0]  i_first,
    input  logic [BW-1:0]  i_stop,
    input  logic [1:0]     i_status,
    output logic           o_busy,
    output logic           o_done,
    output bpfa_pkg::t_rsp o_rsp
);

    localparam int WB    = bpfa_pkg::WORD_BITS;
    localparam int NW    = (NUM_BLOCKS + WB - 1) / WB;
    localparam int AW    = (NW > 1) ? $clog2(NW) : 1;
    localparam int CW    = $clog2(NW + 1);
    localparam int SH    = $clog2(BLOCK_BYTES);
    localparam int LB    = $clog2(WB);

    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_RD    = 6'b000100,
        S_CHK   = 6'b001000,
        S_WR    = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    logic [WB-1:0] mem [NW];
    logic [WB-1:0] r_rdata;

    t_state        r_state;
    logic [CW-1:0] r_waddr;
    logic [1:0]    r_cmd;
    logic [BW-1:0] r_first;
    logic [BW-1:0] r_stop;
    logic [1:0]    r_status;
    logic [31:0]   r_addr;
    logic          r_done;
    logic          r_we;
    logic [WB-1:0] r_wdata;

    logic [WB-1:0] inv;
    logic          found;
    logic [LB-1:0] fbit;
    logic [WB-1:0] msk;
    logic [BW-1:0] wbase;
    logic [BW-1:0] idx;
    logic [WB-1:0] val_valid;

    always_comb begin
        wbase = BW'(r_waddr) << LB;
        for (int b = 0; b < WB; b++) begin
            idx    = wbase + BW'(b);
            msk[b] = (idx >= r_first) && (idx < r_stop);
            val_valid[b] = (idx < BW'(NUM_BLOCKS));
        end
        inv   = ~r_rdata & val_valid;
        found = 1'b0;
        fbit  = '0;
        for (int b = WB - 1; b >= 0; b--) begin
            if (inv[b]) begin
                found = 1'b1;
                fbit  = LB'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            mem[r_waddr[AW-1:0]] <= r_wdata;
        end
        r_rdata <= mem[r_waddr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_waddr <= '0;
            r_done  <= 1'b0;
            r_we    <= 1'b1;
            r_wdata <= '1;
        end else begin
            r_done <= 1'b0;
            r_we   <= 1'b0;
            case (r_state)
                S_INIT: begin
                    r_we    <= 1'b1;
                    if (r_we && r_waddr == CW'(NW - 1)) begin
                        r_we    <= 1'b0;
                        r_waddr <= '0;
                        r_state <= S_IDLE;
                    end else if (r_we) begin
                        r_waddr <= r_waddr + CW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd    <= i_cmd;
                        r_first  <= i_first;
                        r_stop   <= i_stop;
                        r_status <= i_status;
                        r_addr   <= '0;
                        if (i_cmd != bpfa_pkg::CMD_ALLOC && i_first >= i_stop) begin
                            r_state <= S_FIN;
                        end else begin
                            r_waddr <= (i_cmd == bpfa_pkg::CMD_ALLOC) ? '0 :
                                       CW'(i_first >> LB);
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: r_state <= S_CHK;
                S_CHK: begin
                    if (r_cmd == bpfa_pkg::CMD_ALLOC) begin
                        if (found) begin
                            r_wdata <= r_rdata | (WB'(1) << fbit);
                            r_we    <= 1'b1;
                            r_addr  <= 32'({wbase + BW'(fbit), {SH{1'b0}}});
                            r_state <= S_FIN;
                        end else if (r_waddr == CW'(NW - 1)) begin
                            r_status <= bpfa_pkg::ST_FULL;
                            r_state  <= S_FIN;
                        end else begin
                            r_waddr <= r_waddr + CW'(1);
                            r_state <= S_RD;
                        end
                    end else begin
                        r_wdata <= (r_cmd == bpfa_pkg::CMD_RESERVE) ?
                                   (r_rdata | msk) : (r_rdata & ~msk);
                        r_we    <= 1'b1;
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    if ((wbase + BW'(WB)) >= r_stop) begin
                        r_state <= S_FIN;
                    end else begin
                        r_waddr <= r_waddr + CW'(1);
                        r_state <= S_RD;
                    end
                end
                S_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = '{frame_addr: r_addr, status: r_status};

endmodule

// ----- rtl/core/bpfa_checker.sv -----
module bpfa_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_start,
    input logic           o_busy,
    input logic           o_done,
    input bpfa_pkg::t_rsp o_rsp
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("busy not raised");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy)) else $error("result without transaction");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.status != 2'd3)) else $error("bad status");

    a_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != bpfa_pkg::ST_OK) |-> (o_rsp.frame_addr == 32'd0))
        else $error("address on failure");

endmodule

bind bitmap_page_frame_allocator_top bpfa_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
    .o_busy(o_busy), .o_done(o_done), .o_rsp(o_rsp)
);

// ----- verif/tb_bitmap_page_frame_allocator_top.sv -----
module tb_bitmap_page_frame_allocator_top;

    localparam int NUM_BLOCKS  = 4096;
    localparam int BLOCK_BYTES = 4096;
    localparam int LIMIT       = 200000;
    localparam int REQ_W       = $bits(bpfa_pkg::t_req);

    logic           i_clk;
    logic           i_rst_n = 1'b0;
    logic           i_start;
    bpfa_pkg::t_req i_cmd;
    logic           o_busy;
    logic           o_done;
    bpfa_pkg::t_rsp o_rsp;

    bitmap_page_frame_allocator_top #(
        .NUM_BLOCKS(NUM_BLOCKS),
        .BLOCK_BYTES(BLOCK_BYTES)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_cmd(i_cmd),
        .o_busy(o_busy),
        .o_done(o_done),
        .o_rsp(o_rsp)
    );

    bit             page_used [NUM_BLOCKS] = '{default: 1'b1};
    bpfa_pkg::t_req pending_cmds[$];
    bpfa_pkg::t_rsp expected_rsps[$];
    int     error_count = 0;
    int     idle_percent = 0;
    int     quiet_cycles = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic report(input string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    function automatic bpfa_pkg::t_rsp predict_page_op(input bpfa_pkg::t_req req);
        bpfa_pkg::t_rsp rsp;
        longint     first;
        longint     last;
        longint     stop;
        bit         found;
        rsp = '0;
        rsp.status = bpfa_pkg::ST_OK;
        case (bpfa_pkg::t_cmd'(req.command))
            bpfa_pkg::CMD_ALLOC: begin
                found = 0;
                for (int k = 0; k < NUM_BLOCKS && !found; k++) begin
                    if (!page_used[k]) begin
                        found = 1;
                        page_used[k] = 1;
                        rsp.frame_addr = 32'(longint'(k) * BLOCK_BYTES);
                    end
                end
                if (!found) rsp.status = bpfa_pkg::ST_FULL;
            end
            bpfa_pkg::CMD_FREE: begin
                first = longint'(req.address) / BLOCK_BYTES;
                if (first < NUM_BLOCKS) page_used[first] = 0;
                else rsp.status = bpfa_pkg::ST_RANGE;
            end
            default: begin
                first = longint'(req.address) / BLOCK_BYTES;
                last = first + longint'(req.length) / BLOCK_BYTES;
                stop = (last > NUM_BLOCKS) ? NUM_BLOCKS : last;
                for (longint k = first; k < stop; k++)
                    page_used[k] = (bpfa_pkg::t_cmd'(req.command) == bpfa_pkg::CMD_RESERVE);
                if (last > first && last > NUM_BLOCKS) rsp.status = bpfa_pkg::ST_RANGE;
            end
        endcase
        return rsp;
    endfunction

    function automatic bpfa_pkg::t_req make_req(input bpfa_pkg::t_cmd c,
                                                input logic [31:0] a,
                                                input logic [31:0] l);
        bpfa_pkg::t_req r;
        r.command = c;
        r.address = a;
        r.length = l;
        return r;
    endfunction

    function automatic logic [31:0] rand_addr();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 200) * BLOCK_BYTES + $urandom_range(0, BLOCK_BYTES - 1);
            default: return $urandom_range(0, NUM_BLOCKS * BLOCK_BYTES - 1);
        endcase
    endfunction

    function automatic logic [31:0] rand_len();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return $urandom_range(0, BLOCK_BYTES - 1);
            default: return $urandom_range(0, 300) * BLOCK_BYTES + $urandom_range(0, 4095);
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
            i_cmd <= '0;
        end else if (!i_start || !o_busy) begin
            if (i_start)
                expected_rsps.push_back(predict_page_op(i_cmd));
            if (pending_cmds.size() > 0 && $urandom_range(1, 100) > idle_percent) begin
                i_start <= 1'b1;
                i_cmd <= pending_cmds.pop_front();
            end else begin
                i_start <= 1'b0;
                i_cmd <= bpfa_pkg::t_req'(REQ_W'({$urandom(), $urandom(), $urandom()}));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_rsps.size() == 0) begin
                report("result transaction with no expectation");
            end else begin
                bpfa_pkg::t_rsp exp_rsp;
                exp_rsp = expected_rsps.pop_front();
                if (o_rsp.frame_addr !== exp_rsp.frame_addr)
                    report($sformatf("frame_addr %h, expected %h",
                                     o_rsp.frame_addr, exp_rsp.frame_addr));
                if (o_rsp.status !== exp_rsp.status)
                    report($sformatf("status %0d, expected %0d",
                                     o_rsp.status, exp_rsp.status));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (i_start && !o_busy)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || i_start || expected_rsps.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pending_cmds.push_back(make_req(bpfa_pkg::CMD_ALLOC, 0, 0));
        pending_cmds.push_back(make_req(bpfa_pkg::CMD_FREE, 32'hFFFF_FFFF, 0));
        pending_cmds.push_back(make_req(bpfa_pkg::CMD_FREE, NUM_BLOCKS * BLOCK_BYTES, 0));
        pending_cmds.push_back(make_req(bpfa_pkg::CMD_FREE, 0, 0));
        pending_cmds.push_back(make_req(bpfa_pkg::CMD_ALLOC, 0, 0));
        pending_cmds.push_back(make_req(bpfa_pkg::CMD_ALLOC, 0, 0));
        pending_cmds.push_back(make_req(bpfa_pkg::CMD_RELEASE, 0, 100 * BLOCK_BYTES + 5));
        pending_cmds.push_back(make_req(bpfa_pkg::CMD_RELEASE, 32'h1234, BLOCK_BYTES - 1));
        pending_cmds.push_back(make_req(bpfa_pkg::CMD_RESERVE, 32'hFFFF_FFFF,
                                        32'hFFFF_FFFF));
        pending_cmds.push_back(make_req(bpfa_pkg::CMD_RELEASE, 32'hFFFF_FFFF, 0));
        pending_cmds.push_back(make_req(bpfa_pkg::CMD_RELEASE,
                                        (NUM_BLOCKS - 2) * BLOCK_BYTES, 32'hFFFF_FFFF));
        pending_cmds.push_back(make_req(bpfa_pkg::CMD_ALLOC, 0, 0));
        pending_cmds.push_back(make_req(bpfa_pkg::CMD_FREE, 5 * BLOCK_BYTES, 0));
        pending_cmds.push_back(make_req(bpfa_pkg::CMD_FREE, 5 * BLOCK_BYTES + 7, 0));
        pending_cmds.push_back(make_req(bpfa_pkg::CMD_ALLOC, 0, 0));
        pending_cmds.push_back(make_req(bpfa_pkg::CMD_RESERVE, 0, 32'hFFFF_FFFF));
        pending_cmds.push_back(make_req(bpfa_pkg::CMD_ALLOC, 0, 0));
        pending_cmds.push_back(make_req(bpfa_pkg::CMD_RESERVE, 0, BLOCK_BYTES));
        pending_cmds.push_back(make_req(bpfa_pkg::CMD_RELEASE,
                                        (NUM_BLOCKS - 1) * BLOCK_BYTES, BLOCK_BYTES));
        pending_cmds.push_back(make_req(bpfa_pkg::CMD_ALLOC, 0, 0));
        pending_cmds.push_back(make_req(bpfa_pkg::CMD_ALLOC, 0, 0));
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            idle_percent = (phase == 1) ? 78 : (phase == 3) ? 14 : 0;
            for (int n = 0; n < 190; n++) begin
                int sel;
                sel = $urandom_range(0, 99);
                if (sel < 40)
                    pending_cmds.push_back(make_req(bpfa_pkg::CMD_ALLOC, $urandom(),
                                                    $urandom()));
                else if (sel < 65)
                    pending_cmds.push_back(make_req(bpfa_pkg::CMD_FREE, rand_addr(),
                                                    $urandom()));
                else if (sel < 85)
                    pending_cmds.push_back(make_req(bpfa_pkg::CMD_RELEASE, rand_addr(),
                                                    rand_len()));
                else
                    pending_cmds.push_back(make_req(bpfa_pkg::CMD_RESERVE, rand_addr(),
                                                    rand_len()));
            end
            wait_drained();
        end
        repeat (50) @(posedge i_clk);

        if (error_count == 0 && expected_rsps.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
